// File: rtl/core/urte_pkg.sv
// ----------------------------------------------------------------------------
// urte_pkg
// Shared types and constants for the unary report tally and estimate block.
// ----------------------------------------------------------------------------
package urte_pkg;

    // Cells in the report and width of each cell's tally counter.
    localparam int REPORT_CELLS = 32;
    localparam int COUNT_BITS   = 20;

    // Only cells that the 32-bit report can reach are tallied and emitted.
    localparam int EMIT_CELLS = (REPORT_CELLS < 32) ? REPORT_CELLS : 32;
    localparam int IDX_W      = (EMIT_CELLS > 1) ? $clog2(EMIT_CELLS) : 1;

    // Field widths of the ports.
    localparam int REPORT_W   = 32;
    localparam int CELL_IDX_W = 5;
    localparam int RAW_W      = 20;
    localparam int EST_W      = 32;
    localparam int BIAS_W     = 20;
    localparam int GAIN_W     = 16;

    // Bias-corrected difference and its product with the gain.
    localparam int DIFF_W = (COUNT_BITS > BIAS_W) ? COUNT_BITS : BIAS_W;
    localparam int PROD_W = DIFF_W + GAIN_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BIAS_W;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q8    = 1'd1;

    localparam logic [BIAS_W-1:0] BIAS_RESET = 20'd500;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd284;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // One cell handed from the sequencer to the estimate pipeline.
    typedef struct packed {
        logic vld;
        idx_t pos;
        logic last;
    } emit_issue_t;

endpackage

// File: rtl/core/urte_lane.sv
// ----------------------------------------------------------------------------
// urte_lane
// One cell's saturating tally counter, cleared once the cell is issued.
// ----------------------------------------------------------------------------
module urte_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            inc,
    input  logic            clr,
    output urte_pkg::count_t count
);

    urte_pkg::count_t count_reg;
    urte_pkg::count_t count_next;

    always_comb
    begin
        count_next = count_reg;
        if (clr)
        begin
            count_next = '0;
        end
        else if (inc && (count_reg != '1))
        begin
            count_next = count_reg + urte_pkg::count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: rtl/core/urte_emit.sv
// ----------------------------------------------------------------------------
// urte_emit
// Merge stage: pick one lane's count, subtract bias, scale by gain, saturate.
// Three stages (select/subtract, multiply, saturate into output register).
// ----------------------------------------------------------------------------
module urte_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  urte_pkg::emit_issue_t              issue,
    input  urte_pkg::count_t                   counts [urte_pkg::EMIT_CELLS],
    input  logic [urte_pkg::BIAS_W-1:0]        bias,
    input  logic [urte_pkg::GAIN_W-1:0]        gain,
    output logic                               adv,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [urte_pkg::CELL_IDX_W-1:0]    cell_index,
    output logic [urte_pkg::RAW_W-1:0]         raw_count,
    output logic [urte_pkg::EST_W-1:0]         estimate_q8,
    output logic                               last_cell
);

    // stage 1: selected count and clamped difference
    logic                            s1_vld_reg;
    urte_pkg::idx_t                  s1_idx_reg;
    logic [urte_pkg::RAW_W-1:0]      s1_raw_reg;
    logic [urte_pkg::DIFF_W-1:0]     s1_diff_reg;
    logic                            s1_last_reg;

    // stage 2: product
    logic                            s2_vld_reg;
    urte_pkg::idx_t                  s2_idx_reg;
    logic [urte_pkg::RAW_W-1:0]      s2_raw_reg;
    logic [urte_pkg::PROD_W-1:0]     s2_prod_reg;
    logic                            s2_last_reg;

    // stage 3: output register
    logic                            out_vld_reg;
    logic [urte_pkg::CELL_IDX_W-1:0] out_idx_reg;
    logic [urte_pkg::RAW_W-1:0]      out_raw_reg;
    logic [urte_pkg::EST_W-1:0]      out_est_reg;
    logic                            out_last_reg;

    urte_pkg::count_t                sel_count;
    logic [urte_pkg::DIFF_W-1:0]     count_ext;
    logic [urte_pkg::DIFF_W-1:0]     bias_ext;
    logic [urte_pkg::DIFF_W-1:0]     diff_next;
    logic [urte_pkg::PROD_W-1:0]     prod_next;
    logic [urte_pkg::EST_W-1:0]      est_next;

    // advance the whole pipe whenever the output register can move
    assign adv = !out_vld_reg || !out_stall;

    always_comb
    begin
        sel_count = counts[issue.pos];
        count_ext = urte_pkg::DIFF_W'(sel_count);
        bias_ext  = urte_pkg::DIFF_W'(bias);
        diff_next = (count_ext > bias_ext) ? (count_ext - bias_ext) : '0;
        prod_next = urte_pkg::PROD_W'(s1_diff_reg) * urte_pkg::PROD_W'(gain);
        est_next  = (64'(s2_prod_reg) > 64'h0000_0000_FFFF_FFFF)
                  ? '1 : urte_pkg::EST_W'(s2_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= issue.vld;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg   <= issue.pos;
            s1_raw_reg   <= urte_pkg::RAW_W'(sel_count);
            s1_diff_reg  <= diff_next;
            s1_last_reg  <= issue.last;

            s2_idx_reg   <= s1_idx_reg;
            s2_raw_reg   <= s1_raw_reg;
            s2_prod_reg  <= prod_next;
            s2_last_reg  <= s1_last_reg;

            out_idx_reg  <= urte_pkg::CELL_IDX_W'(s2_idx_reg);
            out_raw_reg  <= s2_raw_reg;
            out_est_reg  <= est_next;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign cell_index  = out_idx_reg;
    assign raw_count   = out_raw_reg;
    assign estimate_q8 = out_est_reg;
    assign last_cell   = out_last_reg;

endmodule

// File: rtl/core/unary_report_tally_estimate.sv
// ----------------------------------------------------------------------------
// unary_report_tally_estimate
// Tallies unary-encoded reports per cell and emits debiased estimates.
// ----------------------------------------------------------------------------
// Reports enter at one beat per cycle: every cell has its own saturating
// counter lane, so all set bits of a report are counted in the same cycle.
// The report flagged last is counted too, and then the block stalls its input
// while a sequencer walks the cells in ascending order, one per advancing
// cycle, through a three-stage merge pipeline (select and subtract bias,
// multiply by gain, saturate). Each cell gives one output beat with its raw
// count and estimate max(0, count - bias_count) * gain_q8 in Q24.8, clipped
// at all ones; last_cell marks the final cell. A lane is cleared as its cell
// is issued, so the next population can start as soon as the last cell has
// entered the pipeline; output stall holds the whole pipeline and the walk.
// Each cell passes the stage-1, stage-2 and output registers in turn. Write
// bias_count (index 0) and gain_q8 (index 1) only while no results are
// outstanding; the config port is always ready.
// ----------------------------------------------------------------------------
module unary_report_tally_estimate (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [urte_pkg::REPORT_W-1:0]       report_bits,
    input  logic                                last,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [urte_pkg::CELL_IDX_W-1:0]     cell_index,
    output logic [urte_pkg::RAW_W-1:0]          raw_count,
    output logic [urte_pkg::EST_W-1:0]          estimate_q8,
    output logic                                last_cell,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [urte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urte_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam urte_pkg::idx_t LAST_POS = urte_pkg::IDX_W'(urte_pkg::EMIT_CELLS - 1);

    logic [urte_pkg::BIAS_W-1:0] bias_reg;
    logic [urte_pkg::GAIN_W-1:0] gain_reg;

    logic                        busy_reg;
    logic                        busy_next;
    urte_pkg::idx_t              pos_reg;
    urte_pkg::idx_t              pos_next;

    logic                        in_fire;
    logic                        issue_fire;
    logic                        adv;
    urte_pkg::emit_issue_t       issue;
    urte_pkg::count_t            counts [urte_pkg::EMIT_CELLS];

    // ---------------------------------------------------------------------
    // Configuration registers: always ready; the user must write them only while idle, the block does not enforce it.
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= urte_pkg::BIAS_RESET;
            gain_reg <= urte_pkg::GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                urte_pkg::REG_BIAS_COUNT: bias_reg <= cfg_data;
                urte_pkg::REG_GAIN_Q8:    gain_reg <= cfg_data[urte_pkg::GAIN_W-1:0];
                default:                  bias_reg <= bias_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input side: stall only while cells are being walked.
    // ---------------------------------------------------------------------
    assign in_stall   = busy_reg;
    assign in_fire    = in_valid && !busy_reg;
    assign issue_fire = busy_reg && adv;

    // ---------------------------------------------------------------------
    // Emission walk: one cell per advancing cycle, last cell ends the walk.
    // ---------------------------------------------------------------------
    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (issue_fire)
        begin
            if (pos_reg == LAST_POS)
            begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + urte_pkg::idx_t'(1);
            end
        end
        else if (in_fire && last)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    assign issue.vld  = busy_reg;
    assign issue.pos  = pos_reg;
    assign issue.last = (pos_reg == LAST_POS);

    // ---------------------------------------------------------------------
    // Counter lanes: bump on a set report bit, drop when the cell is issued.
    // Report bits above the cell count are ignored.
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < urte_pkg::EMIT_CELLS; i++)
    begin : g_lane
        urte_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .inc   (in_fire && report_bits[i]),
            .clr   (issue_fire && (pos_reg == urte_pkg::IDX_W'(i))),
            .count (counts[i])
        );
    end

    // ---------------------------------------------------------------------
    // Merge pipeline and output register.
    // ---------------------------------------------------------------------
    urte_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .counts      (counts),
        .bias        (bias_reg),
        .gain        (gain_reg),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_index  (cell_index),
        .raw_count   (raw_count),
        .estimate_q8 (estimate_q8),
        .last_cell   (last_cell)
    );

endmodule

// File: rtl/core/urte_checker.sv
// ----------------------------------------------------------------------------
// urte_checker
// Port-level checks for the unary report tally and estimate block.
// ----------------------------------------------------------------------------
module urte_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             last,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [urte_pkg::CELL_IDX_W-1:0]  cell_index,
    input logic [urte_pkg::RAW_W-1:0]       raw_count,
    input logic                             last_cell
);

    // a stalled output beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its cell index and raw count
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cell_index) && $stable(raw_count))
        else $error("output payload changed while stalled");

    // the final report of a population starts the walk and holds the input
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not held after final report");

    // the last_cell flag rides only on the highest cell
    a_last_cell_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_cell |->
            cell_index == urte_pkg::CELL_IDX_W'(urte_pkg::EMIT_CELLS - 1))
        else $error("last_cell on wrong cell");

    // cells come out in ascending order within a walk
    a_cell_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_cell ##1 out_valid |->
            cell_index == $past(cell_index) + urte_pkg::CELL_IDX_W'(1))
        else $error("cell order broken");

endmodule

bind unary_report_tally_estimate urte_checker u_urte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_index (cell_index),
    .raw_count  (raw_count),
    .last_cell  (last_cell)
);
